FILE: rtl/core/cfb_pkg.sv
// cfb_pkg: shared types, constants and the crc byte update for the frame builder
// no dependencies; imported by every cfb_* module and the top level
`default_nettype none

package cfb_pkg;

    localparam int LEN_W   = 9;
    localparam int WORD_W  = 16;
    localparam int BYTE_W  = 8;

    localparam logic [LEN_W-1:0]  MAX_PAYLOAD  = 9'd256;
    localparam logic [WORD_W-1:0] LEN_OVERHEAD = 16'd8;
    localparam logic [BYTE_W-1:0] SYNC_HEAD    = 8'hA5;
    localparam logic [BYTE_W-1:0] SYNC_TAIL    = 8'h5A;
    localparam logic [WORD_W-1:0] CRC_INIT     = 16'hFFFF;
    localparam logic [WORD_W-1:0] CRC_POLY     = 16'h1021;

    // job queue between front and back, depth a power of two
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    localparam logic [1:0] KIND_ERR = 2'd0;
    localparam logic [1:0] KIND_HDR = 2'd1;
    localparam logic [1:0] KIND_PAY = 2'd2;

    typedef struct packed {
        logic [1:0]        kind;
        logic              close;   // frame tail follows this job
        logic [WORD_W-1:0] flen;
        logic [WORD_W-1:0] seq;
        logic [WORD_W-1:0] cmd;
        logic [BYTE_W-1:0] pbyte;
    } t_job;

    function automatic logic [WORD_W-1:0] crc_byte(input logic [WORD_W-1:0] crc,
                                                   input logic [BYTE_W-1:0] b);
        logic [WORD_W-1:0] c;
        c = crc ^ {b, 8'h00};
        for (int i = 0; i < 8; i++) begin
            if (c[WORD_W-1]) begin
                c = {c[WORD_W-2:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[WORD_W-2:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/core/cfb_front.sv
// cfb_front: accepts items, tracks the open frame and turns each item into a job
// depends on cfb_pkg
`default_nettype none

module cfb_front (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_accept,
    input  wire logic                      i_op,
    input  wire logic [cfb_pkg::WORD_W-1:0] i_seq_num,
    input  wire logic [cfb_pkg::WORD_W-1:0] i_command,
    input  wire logic [cfb_pkg::LEN_W-1:0]  i_payload_len,
    input  wire logic [cfb_pkg::BYTE_W-1:0] i_payload_byte,
    output cfb_pkg::t_job                  o_job
);
    import cfb_pkg::*;

    logic             r_open, n_open;
    logic [LEN_W-1:0] r_left, n_left;
    t_job             job;

    always_comb begin
        job    = '0;
        n_open = r_open;
        n_left = r_left;
        if (!i_op) begin
            if (r_open || (i_payload_len > MAX_PAYLOAD)) begin
                job.kind = KIND_ERR;
            end else begin
                job.kind  = KIND_HDR;
                job.flen  = {{(WORD_W-LEN_W){1'b0}}, i_payload_len} + LEN_OVERHEAD;
                job.seq   = i_seq_num;
                job.cmd   = i_command;
                job.close = (i_payload_len == '0);
                n_open    = (i_payload_len != '0);
                n_left    = i_payload_len;
            end
        end else begin
            if (!r_open) begin
                job.kind = KIND_ERR;
            end else begin
                job.kind  = KIND_PAY;
                job.pbyte = i_payload_byte;
                job.close = (r_left == LEN_W'(1));
                n_left    = r_left - LEN_W'(1);
                n_open    = (r_left != LEN_W'(1));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open <= 1'b0;
            r_left <= '0;
        end else if (i_accept) begin
            r_open <= n_open;
            r_left <= n_left;
        end
    end

    assign o_job = job;

endmodule

`default_nettype wire

FILE: rtl/core/cfb_queue.sv
// cfb_queue: short job queue that decouples the front from the back
// depends on cfb_pkg
`default_nettype none

module cfb_queue (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_push,
    input  wire cfb_pkg::t_job i_job,
    input  wire logic    i_pop,
    output cfb_pkg::t_job o_job,
    output logic         o_valid,
    output logic         o_full
);
    import cfb_pkg::*;

    t_job              r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;
    logic              do_push;
    logic              do_pop;

    assign o_full  = (r_count == QCNT_W'(QDEPTH));
    assign o_valid = (r_count != '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;
    assign o_job   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + QPTR_W'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + QPTR_W'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + QCNT_W'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - QCNT_W'(1);
            end
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/cfb_back.sv
// cfb_back: walks each job byte by byte, keeps the running crc, drives the output register
// depends on cfb_pkg
`default_nettype none

module cfb_back (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire cfb_pkg::t_job             i_job,
    input  wire logic                      i_job_valid,
    output logic                           o_job_done,
    input  wire logic                      i_pop,
    output logic                           o_valid,
    output logic [cfb_pkg::BYTE_W-1:0]     o_byte,
    output logic                           o_frame_end,
    output logic                           o_run_last,
    output logic                           o_error
);
    import cfb_pkg::*;

    // byte positions within a frame
    localparam logic [3:0] POS_HEAD0   = 4'd0;
    localparam logic [3:0] POS_HEAD1   = 4'd1;
    localparam logic [3:0] POS_LEN_HI  = 4'd2;
    localparam logic [3:0] POS_LEN_LO  = 4'd3;
    localparam logic [3:0] POS_SEQ_HI  = 4'd4;
    localparam logic [3:0] POS_SEQ_LO  = 4'd5;
    localparam logic [3:0] POS_CMD_HI  = 4'd6;
    localparam logic [3:0] POS_CMD_LO  = 4'd7;
    localparam logic [3:0] POS_CRC_HI  = 4'd8;
    localparam logic [3:0] POS_CRC_LO  = 4'd9;
    localparam logic [3:0] POS_TAIL0   = 4'd10;
    localparam logic [3:0] POS_TAIL1   = 4'd11;
    localparam logic [3:0] POS_PAYLOAD = 4'd12;
    localparam logic [3:0] POS_ERR     = 4'd13;

    logic [3:0]        r_step;
    logic [WORD_W-1:0] r_crc, n_crc;
    logic              r_valid;
    logic [BYTE_W-1:0] r_byte;
    logic              r_frame_end;
    logic              r_run_last;
    logic              r_error;

    logic [3:0]        pos;
    logic [BYTE_W-1:0] b;
    logic              last;
    logic              advance;

    always_comb begin
        case (i_job.kind)
            KIND_HDR: pos = r_step;
            KIND_PAY: pos = (r_step == '0) ? POS_PAYLOAD : r_step + 4'd7;
            default:  pos = POS_ERR;
        endcase
    end

    always_comb begin
        case (pos)
            POS_HEAD0, POS_HEAD1: b = SYNC_HEAD;
            POS_LEN_HI:           b = i_job.flen[15:8];
            POS_LEN_LO:           b = i_job.flen[7:0];
            POS_SEQ_HI:           b = i_job.seq[15:8];
            POS_SEQ_LO:           b = i_job.seq[7:0];
            POS_CMD_HI:           b = i_job.cmd[15:8];
            POS_CMD_LO:           b = i_job.cmd[7:0];
            POS_CRC_HI:           b = r_crc[15:8];
            POS_CRC_LO:           b = r_crc[7:0];
            POS_TAIL0, POS_TAIL1: b = SYNC_TAIL;
            POS_PAYLOAD:          b = i_job.pbyte;
            default:              b = '0;
        endcase
    end

    always_comb begin
        if (pos == POS_LEN_HI) begin
            n_crc = crc_byte(CRC_INIT, b);
        end else if (pos inside {[POS_LEN_LO:POS_CMD_LO], POS_PAYLOAD}) begin
            n_crc = crc_byte(r_crc, b);
        end else if (pos == POS_TAIL1) begin
            n_crc = CRC_INIT;
        end else begin
            n_crc = r_crc;
        end
    end

    assign last = (pos == POS_ERR) || (pos == POS_TAIL1)
               || (!i_job.close && ((pos == POS_CMD_LO) || (pos == POS_PAYLOAD)));
    assign advance    = i_job_valid && (!r_valid || i_pop);
    assign o_job_done = advance && last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step  <= '0;
            r_crc   <= CRC_INIT;
            r_valid <= 1'b0;
        end else begin
            if (advance) begin
                r_step  <= last ? 4'd0 : r_step + 4'd1;
                r_crc   <= n_crc;
                r_valid <= 1'b1;
            end else if (i_pop) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_byte      <= b;
            r_frame_end <= (pos == POS_TAIL1);
            r_run_last  <= last;
            r_error     <= (pos == POS_ERR);
        end
    end

    assign o_valid     = r_valid;
    assign o_byte      = r_byte;
    assign o_frame_end = r_frame_end;
    assign o_run_last  = r_run_last;
    assign o_error     = r_error;

endmodule

`default_nettype wire

FILE: rtl/core/crc16_frame_builder_unit.sv
// crc16_frame_builder_unit: byte framer with crc-16/ccitt-false, top level
// depends on cfb_pkg, cfb_front, cfb_queue, cfb_back
//
// input side is a queue write port: an item is taken on a clock edge with push high
// and full low. op low is a header item (seq_num, command, payload_len), op high a
// payload byte item. result side is a queue read port: while empty is low the oldest
// frame byte sits on o_out_byte with its flags, and pop takes it.
// a good header gives 8 bytes (a5 a5, length+8, sequence, command), or 12 when the
// payload length is zero; a payload byte gives one byte, or 5 when it is the last one
// (crc high, crc low, 5a 5a). a rejected item gives one byte flagged o_error.
// an item's first byte passes the job queue, then the back-end output register.
// throughput: one output byte per cycle while pop is high, set by the back-end
// sequencer; payload items but the last stream at one per cycle, a header holds
// the back end for its 8 or 12 bytes, and the four-entry job queue lets the input
// side run ahead by that many items. when pop stays low the output register holds,
// the back end stops, and full rises once the job queue fills.
// synchronous reset empties the queue and the output, and closes any open frame.
`default_nettype none

module crc16_frame_builder_unit (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      push,
    output logic                           full,
    input  wire logic                      i_op,
    input  wire logic [cfb_pkg::WORD_W-1:0] i_seq_num,
    input  wire logic [cfb_pkg::WORD_W-1:0] i_command,
    input  wire logic [cfb_pkg::LEN_W-1:0]  i_payload_len,
    input  wire logic [cfb_pkg::BYTE_W-1:0] i_payload_byte,
    output logic                           empty,
    input  wire logic                      pop,
    output logic [cfb_pkg::BYTE_W-1:0]     o_out_byte,
    output logic                           o_frame_end,
    output logic                           o_run_last,
    output logic                           o_error
);
    import cfb_pkg::*;

    t_job front_job;
    t_job head_job;
    logic accept;
    logic q_full;
    logic q_valid;
    logic job_done;
    logic out_valid;

    assign accept = push && !q_full;
    assign full   = q_full;
    assign empty  = !out_valid;

    cfb_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_accept       (accept),
        .i_op           (i_op),
        .i_seq_num      (i_seq_num),
        .i_command      (i_command),
        .i_payload_len  (i_payload_len),
        .i_payload_byte (i_payload_byte),
        .o_job          (front_job)
    );

    cfb_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (accept),
        .i_job   (front_job),
        .i_pop   (job_done),
        .o_job   (head_job),
        .o_valid (q_valid),
        .o_full  (q_full)
    );

    cfb_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job       (head_job),
        .i_job_valid (q_valid),
        .o_job_done  (job_done),
        .i_pop       (pop),
        .o_valid     (out_valid),
        .o_byte      (o_out_byte),
        .o_frame_end (o_frame_end),
        .o_run_last  (o_run_last),
        .o_error     (o_error)
    );

    // a rejected item gives a single zero byte
    a_err_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_error) |-> (o_out_byte == '0 && o_run_last && !o_frame_end))
        else $error("error result malformed");

    // a frame only ends on the last byte of an item
    a_end_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_frame_end) |-> (o_run_last && o_out_byte == SYNC_TAIL))
        else $error("frame end not on final tail byte");

    // reset leaves nothing to read
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> empty)
        else $error("output not empty after reset");

endmodule

`default_nettype wire

FILE: verif/tb_crc16_frame_builder_unit.sv
// tb_crc16_frame_builder_unit: self-checking bench for the crc-16 frame builder
// drives header and payload items through the push side, predicts every frame byte
// with its own crc and frame state, and checks the pop side; depends on cfb_pkg
module tb_crc16_frame_builder_unit;

    localparam logic OP_HEADER  = 1'b0;
    localparam logic OP_PAYLOAD = 1'b1;

    localparam int IDLE_LIMIT    = 4000;
    localparam int HOLDOFF_LEN   = 400;
    localparam int HOLDOFF_AFTER = 200;
    localparam int TAIL_CYCLES   = 40;
    localparam int RANDOM_ITEMS  = 210;
    localparam int IDLE_FRAME    = 24;
    localparam int LAST_PAYLOADS = 20;
    localparam int MAX_REPORTS   = 10;

    typedef enum logic [1:0] {POP_STEADY, POP_RANDOM, POP_SPARSE} t_pop_mode;

    typedef struct packed {
        logic                         wait_idle;   // hold until every result is in
        logic                         op;
        logic [cfb_pkg::WORD_W-1:0]   seq_num;
        logic [cfb_pkg::WORD_W-1:0]   command;
        logic [cfb_pkg::LEN_W-1:0]    payload_len;
        logic [cfb_pkg::BYTE_W-1:0]   payload_byte;
    } t_frame_item;

    typedef struct packed {
        logic [cfb_pkg::BYTE_W-1:0] data;
        logic                       frame_end;
        logic                       run_last;
        logic                       error;
    } t_frame_byte;

    logic                         i_clk          = 1'b0;
    logic                         i_rst_n        = 1'b0;
    logic                         push           = 1'b0;
    logic                         pop            = 1'b0;
    logic                         i_op           = 1'b0;
    logic [cfb_pkg::WORD_W-1:0]   i_seq_num      = '0;
    logic [cfb_pkg::WORD_W-1:0]   i_command      = '0;
    logic [cfb_pkg::LEN_W-1:0]    i_payload_len  = '0;
    logic [cfb_pkg::BYTE_W-1:0]   i_payload_byte = '0;
    logic                         full;
    logic                         empty;
    logic [cfb_pkg::BYTE_W-1:0]   o_out_byte;
    logic                         o_frame_end;
    logic                         o_run_last;
    logic                         o_error;

    crc16_frame_builder_unit dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .push           (push),
        .full           (full),
        .i_op           (i_op),
        .i_seq_num      (i_seq_num),
        .i_command      (i_command),
        .i_payload_len  (i_payload_len),
        .i_payload_byte (i_payload_byte),
        .empty          (empty),
        .pop            (pop),
        .o_out_byte     (o_out_byte),
        .o_frame_end    (o_frame_end),
        .o_run_last     (o_run_last),
        .o_error        (o_error)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    t_frame_item pending_items[$];
    t_frame_byte frame_bytes_due[$];

    // predicted framer state
    logic [cfb_pkg::WORD_W-1:0] frame_crc       = cfb_pkg::CRC_INIT;
    logic [cfb_pkg::LEN_W-1:0]  payload_pending = '0;
    logic                       frame_is_open   = 1'b0;

    // frame state as the stimulus list is built, before anything runs
    bit plan_open = 1'b0;
    int plan_left = 0;

    int items_accepted  = 0;
    int bytes_checked   = 0;
    int frames_closed   = 0;
    int items_rejected  = 0;
    int mismatches      = 0;
    int burst_left      = 8;
    int gap_left        = 0;
    int holdoff_left    = 0;
    int phase_left      = 0;
    int idle_cycles     = 0;
    bit holdoff_done    = 1'b0;
    bit flushing        = 1'b0;
    t_pop_mode pop_mode = POP_STEADY;

    function automatic logic [15:0] crc_ccitt_step(input logic [15:0] crc,
                                                   input logic [7:0] data);
        logic [15:0] c;
        logic        fb;
        c = crc;
        for (int i = 7; i >= 0; i--) begin
            fb = c[15] ^ data[i];
            c  = {c[14:0], 1'b0} ^ (fb ? cfb_pkg::CRC_POLY : 16'h0000);
        end
        return c;
    endfunction

    function automatic void note_byte(input logic [7:0] data, input logic frame_end);
        frame_bytes_due.push_back('{data: data, frame_end: frame_end,
                                    run_last: 1'b0, error: 1'b0});
    endfunction

    function automatic void note_crc_byte(input logic [7:0] data);
        frame_crc = crc_ccitt_step(frame_crc, data);
        note_byte(data, 1'b0);
    endfunction

    function automatic void close_frame();
        note_byte(frame_crc[15:8], 1'b0);
        note_byte(frame_crc[7:0], 1'b0);
        note_byte(cfb_pkg::SYNC_TAIL, 1'b0);
        note_byte(cfb_pkg::SYNC_TAIL, 1'b1);
        frame_is_open   = 1'b0;
        payload_pending = '0;
        frame_crc       = cfb_pkg::CRC_INIT;
        frames_closed++;
    endfunction

    // works out the frame bytes that one accepted item gives
    function automatic void predict_frame_bytes(input t_frame_item it);
        logic [15:0] flen;
        t_frame_byte last_byte;
        if ((it.op == OP_HEADER && (frame_is_open || it.payload_len > cfb_pkg::MAX_PAYLOAD))
                || (it.op == OP_PAYLOAD && !frame_is_open)) begin
            frame_bytes_due.push_back('{data: 8'h00, frame_end: 1'b0,
                                        run_last: 1'b1, error: 1'b1});
            items_rejected++;
            return;
        end
        if (it.op == OP_HEADER) begin
            flen      = {7'd0, it.payload_len} + cfb_pkg::LEN_OVERHEAD;
            frame_crc = cfb_pkg::CRC_INIT;
            note_byte(cfb_pkg::SYNC_HEAD, 1'b0);
            note_byte(cfb_pkg::SYNC_HEAD, 1'b0);
            note_crc_byte(flen[15:8]);
            note_crc_byte(flen[7:0]);
            note_crc_byte(it.seq_num[15:8]);
            note_crc_byte(it.seq_num[7:0]);
            note_crc_byte(it.command[15:8]);
            note_crc_byte(it.command[7:0]);
            if (it.payload_len == '0) begin
                close_frame();
            end else begin
                frame_is_open   = 1'b1;
                payload_pending = it.payload_len;
            end
        end else begin
            note_crc_byte(it.payload_byte);
            payload_pending = payload_pending - 9'd1;
            if (payload_pending == '0) begin
                close_frame();
            end
        end
        last_byte = frame_bytes_due.pop_back();
        last_byte.run_last = 1'b1;
        frame_bytes_due.push_back(last_byte);
    endfunction

    function automatic void add_item(input logic op, input logic [15:0] seq,
                                     input logic [15:0] cmd, input logic [8:0] len,
                                     input logic [7:0] pbyte, input logic hold);
        pending_items.push_back('{wait_idle: hold, op: op, seq_num: seq, command: cmd,
                                  payload_len: len, payload_byte: pbyte});
        if (op == OP_HEADER) begin
            if (!plan_open && len != '0 && len <= cfb_pkg::MAX_PAYLOAD) begin
                plan_open = 1'b1;
                plan_left = int'(len);
            end
        end else if (plan_open) begin
            plan_left--;
            if (plan_left == 0) begin
                plan_open = 1'b0;
            end
        end
    endfunction

    function automatic void add_random_payload();
        add_item(OP_PAYLOAD, 16'($urandom), 16'($urandom), 9'($urandom), 8'($urandom),
                 1'b0);
    endfunction

    function automatic void add_random_header(input int len, input logic hold);
        add_item(OP_HEADER, 16'($urandom), 16'($urandom), 9'(len), 8'($urandom), hold);
    endfunction

    task automatic report_mismatch(input string what, input t_frame_byte want,
                                   input t_frame_byte got);
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
            $write("%s at byte %0d: expected %02h end %0b last %0b err %0b, ",
                   what, bytes_checked, want.data, want.frame_end, want.run_last,
                   want.error);
            $display("got %02h end %0b last %0b err %0b",
                     got.data, got.frame_end, got.run_last, got.error);
        end
    endtask

    // driver: bursts of items with random gaps, fed from pending_items
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (push && !full) begin
                predict_frame_bytes(pending_items[0]);
                pending_items.delete(0);
                items_accepted++;
                burst_left--;
                if (burst_left <= 0) begin
                    burst_left = $urandom_range(1, 32);
                    gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
                end
            end
            if (!(push && full)) begin
                if (gap_left > 0) begin
                    gap_left--;
                    push <= 1'b0;
                end else if (pending_items.size() != 0 &&
                             !(pending_items[0].wait_idle && frame_bytes_due.size() != 0)) begin
                    push           <= 1'b1;
                    i_op           <= pending_items[0].op;
                    i_seq_num      <= pending_items[0].seq_num;
                    i_command      <= pending_items[0].command;
                    i_payload_len  <= pending_items[0].payload_len;
                    i_payload_byte <= pending_items[0].payload_byte;
                end else begin
                    push <= 1'b0;
                end
            end
        end
    end

    // receiver: pop pattern of its own, plus one long hold-off to fill the block
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (holdoff_left > 0) begin
                holdoff_left--;
                pop <= 1'b0;
            end else if (!holdoff_done && bytes_checked >= HOLDOFF_AFTER) begin
                holdoff_done = 1'b1;
                holdoff_left = HOLDOFF_LEN - 1;
                pop <= 1'b0;
            end else if (flushing) begin
                pop <= 1'b1;
            end else begin
                if (phase_left == 0) begin
                    pop_mode   = t_pop_mode'($urandom_range(0, 2));
                    phase_left = $urandom_range(20, 80);
                end
                phase_left--;
                case (pop_mode)
                    POP_STEADY: begin
                        pop <= 1'b1;
                    end
                    POP_RANDOM: begin
                        pop <= 1'($urandom_range(0, 1));
                    end
                    default: begin
                        pop <= ($urandom_range(0, 3) == 0);
                    end
                endcase
            end
        end
    end

    // monitor: each popped byte against the oldest prediction
    always @(posedge i_clk) begin
        t_frame_byte got;
        t_frame_byte want;
        if (i_rst_n && pop && !empty) begin
            got = '{data: o_out_byte, frame_end: o_frame_end, run_last: o_run_last,
                    error: o_error};
            if (frame_bytes_due.size() == 0) begin
                report_mismatch("unexpected byte", '0, got);
            end else begin
                want = frame_bytes_due.pop_front();
                if (got.data !== want.data || got.frame_end !== want.frame_end ||
                    got.run_last !== want.run_last || got.error !== want.error) begin
                    report_mismatch("mismatch", want, got);
                end
            end
            bytes_checked++;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (push && !full) || (pop && !empty)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("timeout: %0d cycles with no transfer", idle_cycles);
            $display("FAILED: results differ");
            $finish;
        end
    end

    initial begin
        int frame_len;
        int cut;
        int pick;

        // directed: rejects, empty frames, field extremes, short frames
        add_item(OP_PAYLOAD, 16'hFFFF, 16'hFFFF, 9'h1FF, 8'hFF, 1'b0);
        add_item(OP_HEADER, 16'hFFFF, 16'hFFFF, 9'd0, 8'hFF, 1'b0);
        add_item(OP_HEADER, 16'h0000, 16'h0000, 9'd0, 8'h00, 1'b0);
        add_item(OP_HEADER, 16'h0102, 16'h0304, 9'd257, 8'h00, 1'b0);
        add_item(OP_HEADER, 16'hFFFF, 16'h0000, 9'h1FF, 8'h00, 1'b0);
        add_item(OP_HEADER, 16'h1234, 16'hABCD, 9'd1, 8'h00, 1'b0);
        add_item(OP_HEADER, 16'h5555, 16'hAAAA, 9'd0, 8'h00, 1'b0);
        add_item(OP_PAYLOAD, 16'hFFFF, 16'hFFFF, 9'h1FF, 8'h00, 1'b0);
        add_item(OP_HEADER, 16'h8001, 16'h7FFE, 9'd3, 8'hFF, 1'b0);
        add_item(OP_PAYLOAD, 16'h0000, 16'h0000, 9'd0, 8'hFF, 1'b0);
        add_item(OP_PAYLOAD, 16'h0000, 16'h0000, 9'd0, 8'hA5, 1'b0);
        add_item(OP_PAYLOAD, 16'h0000, 16'h0000, 9'd0, 8'h00, 1'b0);
        add_item(OP_PAYLOAD, 16'h0000, 16'h0000, 9'd0, 8'h00, 1'b0);
        add_item(OP_HEADER, 16'h00FF, 16'hFF00, 9'd2, 8'h00, 1'b0);
        add_item(OP_PAYLOAD, 16'h0000, 16'h0000, 9'd0, 8'h5A, 1'b0);
        add_item(OP_PAYLOAD, 16'h0000, 16'h0000, 9'd0, 8'h5A, 1'b0);

        // one longer frame, started from an idle block
        add_random_header(IDLE_FRAME, 1'b1);
        for (int i = 0; i < IDLE_FRAME; i++) begin
            add_random_payload();
        end

        // random: mostly well-formed frames, some rejects and cut-short frames
        while (pending_items.size() < RANDOM_ITEMS - LAST_PAYLOADS - 1) begin
            pick = $urandom_range(0, 19);
            if (pick < 15) begin
                frame_len = ($urandom_range(0, 5) == 0) ? $urandom_range(7, 24)
                                                         : $urandom_range(0, 6);
                add_random_header(frame_len, 1'b0);
                for (int i = 0; i < frame_len; i++) begin
                    if ($urandom_range(0, 15) == 0) begin
                        add_random_header($urandom_range(0, 511), 1'b0);
                    end
                    add_random_payload();
                end
            end else if (pick < 17) begin
                add_random_payload();
            end else if (pick < 19) begin
                add_random_header($urandom_range(257, 511), 1'b0);
            end else begin
                frame_len = $urandom_range(2, 8);
                cut = $urandom_range(1, frame_len - 1);
                add_random_header(frame_len, 1'b0);
                for (int i = 0; i < cut; i++) begin
                    add_random_payload();
                end
            end
        end

        // finish any frame still open, then a header of the largest length left open
        while (plan_open) begin
            add_random_payload();
        end
        add_random_header(int'(cfb_pkg::MAX_PAYLOAD), 1'b0);
        for (int i = 0; i < LAST_PAYLOADS; i++) begin
            add_random_payload();
        end

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_items.size() != 0 || frame_bytes_due.size() != 0) begin
            @(posedge i_clk);
        end
        flushing = 1'b1;
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("%0d items in, %0d frame bytes checked, %0d frames closed, %0d items rejected",
                 items_accepted, bytes_checked, frames_closed, items_rejected);
        $display("covered rejects, empty and short frames, cut-short frames, a %0d-byte header,",
                 cfb_pkg::MAX_PAYLOAD);
        $display("a full input under a long output stall and a pause until the block drained");
        if (mismatches == 0 && frame_bytes_due.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule

FILE: sim.f
rtl/core/cfb_pkg.sv
rtl/core/cfb_front.sv
rtl/core/cfb_queue.sv
rtl/core/cfb_back.sv
rtl/core/crc16_frame_builder_unit.sv
verif/tb_crc16_frame_builder_unit.sv
